/* sv/raster_draw_engine_defines.svh */
// assertion macros for the raster draw engine
`ifndef RASTER_DRAW_ENGINE_DEFINES_SVH
`define RASTER_DRAW_ENGINE_DEFINES_SVH

// condition holds at every edge outside reset
`define RDE_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RDE_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/rde_pkg.sv */
// shared types and constants of the raster draw engine
`default_nettype none
package rde_pkg;

   localparam int CW     = 12;
   localparam int EW     = 13;
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   typedef enum logic [3:0] {
      CMD_PIXEL     = 4'd0,
      CMD_INV_PIXEL = 4'd1,
      CMD_HBYTE     = 4'd2,
      CMD_VBYTE     = 4'd3,
      CMD_VLINE     = 4'd4,
      CMD_HLINE     = 4'd5,
      CMD_RECT      = 4'd6,
      CMD_INV_AREA  = 4'd7,
      CMD_CLR_AREA  = 4'd8,
      CMD_CLEAR     = 4'd9,
      CMD_READ      = 4'd10
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_FG   = 2'd0,
      CSR_BG   = 2'd1,
      CSR_MODE = 2'd2
   } csr_index_type;

   localparam logic [1:0] MODE_OPAQUE = 2'd0;
   localparam logic [1:0] MODE_TRANSP = 2'd1;
   localparam logic [1:0] MODE_INVERT = 2'd2;

   typedef struct packed {
      logic [7:0] fg;
      logic [7:0] bg;
      logic [1:0] mode;
   } cfg_type;

   typedef enum logic [2:0] {
      PK_NOP,
      PK_WRITE,
      PK_INVERT,
      PK_PAT,
      PK_READ
   } prim_kind_type;

   typedef struct packed {
      prim_kind_type         kind;
      logic                  last;
      logic                  vert;
      logic [1:0]            mode;
      logic [7:0]            color;
      logic [7:0]            bg;
      logic [7:0]            bits;
      logic signed [EW-1:0]  x1;
      logic signed [EW-1:0]  x2;
      logic signed [EW-1:0]  y1;
      logic signed [EW-1:0]  y2;
   } prim_type;

   typedef enum logic {
      F_IDLE,
      F_EMIT
   } front_state_type;

   typedef enum logic [2:0] {
      B_INIT,
      B_IDLE,
      B_ROW,
      B_RUN,
      B_INV,
      B_RDW,
      B_DONE
   } back_state_type;

endpackage
`default_nettype wire

/* sv/raster_draw_engine.sv */
// Drawing engine over an internal 8-bit-per-pixel frame store.
// Channels: command words on req_* (valid/stall), one result word per command
// on rsp_* (valid/stall), register writes on csr_* (valid/ready, index 0 fg
// color, 1 bg color, 2 draw mode; always ready).
// The front end registers a command and splits it into up to five area
// primitives pushed into a four-entry queue; the back end clips each area and
// walks it through the single frame store port, one written pixel per cycle;
// an inverted pixel is read and then written back. Throughput is bound by
// that port.
// Reset: a clearing pass over every pixel zeroes the store;
// req_stall stays high meanwhile, register writes are taken as usual.
// A result waits in an output register while rsp_stall is high; the back end
// then holds at its final step and the queue and front end fill behind it.
`default_nettype none
`include "raster_draw_engine_defines.svh"
module raster_draw_engine
   import rde_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [3:0]           req_command,
   input  wire logic signed [CW-1:0] req_x_start,
   input  wire logic signed [CW-1:0] req_x_end,
   input  wire logic signed [CW-1:0] req_y_start,
   input  wire logic signed [CW-1:0] req_y_end,
   input  wire logic [7:0]           req_pixel_color,
   input  wire logic [7:0]           req_pattern_byte,
   input  wire logic                 req_fill_flag,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_read_value,
   output logic                      rsp_read_valid,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [1:0]           csr_index,
   input  wire logic [7:0]           csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   prim_type      q_in_data, q_head;
   logic          q_push, q_pop, q_full, q_empty;
   logic [QAW:0]  q_count;
   logic          init_busy;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FG:   cfg_in.fg   = csr_wdata;
            CSR_BG:   cfg_in.bg   = csr_wdata;
            CSR_MODE: cfg_in.mode = csr_wdata[1:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg   <= 8'hFF;
         cfg_ff.bg   <= 8'h00;
         cfg_ff.mode <= MODE_TRANSP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rde_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_x_start      (req_x_start),
      .req_x_end        (req_x_end),
      .req_y_start      (req_y_start),
      .req_y_end        (req_y_end),
      .req_pixel_color  (req_pixel_color),
      .req_pattern_byte (req_pattern_byte),
      .req_fill_flag    (req_fill_flag),
      .cfg              (cfg_ff),
      .init_busy        (init_busy),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_in_data)
   );

   rde_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty),
      .count     (q_count)
   );

   rde_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (q_head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .init_busy      (init_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_read_valid (rsp_read_valid)
   );

   `RDE_ASSERT_ALWAYS(a_queue_bound, q_count <= (QAW+1)'(QDEPTH), "queue overflow")
   `RDE_ASSERT_IMPLY(a_init_queue_empty, init_busy, q_empty && !rsp_valid, "work during clear pass")
   `RDE_ASSERT_IMPLY(a_no_pop_empty, q_pop, !q_empty, "pop from empty queue")

endmodule
`default_nettype wire

/* sv/rde_queue.sv */
// primitive queue between front and back
`default_nettype none
module rde_queue
   import rde_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire prim_type   push_data,
   input  wire logic       pop,
   output prim_type        head,
   output logic            full,
   output logic            empty,
   output logic [QAW:0]    count
);

   prim_type          slot_ff [QDEPTH];
   logic [QAW-1:0]    wr_ff, wr_in;
   logic [QAW-1:0]    rd_ff, rd_in;
   logic [QAW:0]      cnt_ff, cnt_in;

   assign head  = slot_ff[rd_ff];
   assign full  = (cnt_ff == (QAW+1)'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign count = cnt_ff;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* sv/rde_front.sv */
// command front end: accepts words and splits them into area primitives
`default_nettype none
module rde_front
   import rde_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [3:0]           req_command,
   input  wire logic signed [CW-1:0] req_x_start,
   input  wire logic signed [CW-1:0] req_x_end,
   input  wire logic signed [CW-1:0] req_y_start,
   input  wire logic signed [CW-1:0] req_y_end,
   input  wire logic [7:0]           req_pixel_color,
   input  wire logic [7:0]           req_pattern_byte,
   input  wire logic                 req_fill_flag,
   input  wire cfg_type              cfg,
   input  wire logic                 init_busy,
   input  wire logic                 q_full,
   output logic                      q_push,
   output prim_type                  q_data
);

   front_state_type       state_ff, state_in;
   logic [2:0]            k_ff, k_in;
   logic [3:0]            cmd_ff;
   logic signed [EW-1:0]  x1_ff, x2_ff, y1_ff, y2_ff;
   logic [7:0]            color_ff, bits_ff;
   logic                  fill_ff;
   logic                  accept;
   prim_type              p;
   prim_kind_type         line_kind;

   assign accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_EMIT;
               k_in     = '0;
            end
         end
         F_EMIT: begin
            if (!q_full) begin
               if (p.last) begin
                  state_in = F_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = (state_ff != F_IDLE) || init_busy;
      q_push    = (state_ff == F_EMIT) && !q_full;
      q_data    = p;
   end

   // primitive for the current step
   always_comb begin
      line_kind = (cfg.mode == MODE_INVERT) ? PK_INVERT : PK_WRITE;
      p.kind  = PK_NOP;
      p.last  = 1'b1;
      p.vert  = 1'b0;
      p.mode  = cfg.mode;
      p.color = cfg.fg;
      p.bg    = cfg.bg;
      p.bits  = bits_ff;
      p.x1    = x1_ff;
      p.x2    = x1_ff;
      p.y1    = y1_ff;
      p.y2    = y1_ff;
      case (cmd_ff)
         CMD_PIXEL: begin
            p.kind  = PK_WRITE;
            p.color = color_ff;
         end
         CMD_INV_PIXEL: p.kind = PK_INVERT;
         CMD_HBYTE: begin
            p.kind = PK_PAT;
            p.x2   = x1_ff + EW'(7);
         end
         CMD_VBYTE: begin
            p.kind = PK_PAT;
            p.vert = 1'b1;
            p.y2   = y1_ff + EW'(7);
         end
         CMD_VLINE: begin
            p.kind = line_kind;
            p.y2   = y2_ff;
         end
         CMD_HLINE: begin
            p.kind = line_kind;
            p.x2   = x2_ff;
         end
         CMD_RECT: begin
            p.kind = line_kind;
            p.last = (k_ff == 3'd4) || ((k_ff == 3'd3) && !fill_ff);
            case (k_ff)
               3'd0: p.x2 = x2_ff;
               3'd1: begin
                  p.x2 = x2_ff;
                  p.y1 = y2_ff;
                  p.y2 = y2_ff;
               end
               3'd2: p.y2 = y2_ff;
               3'd3: begin
                  p.x1 = x2_ff;
                  p.x2 = x2_ff;
                  p.y2 = y2_ff;
               end
               default: begin
                  p.x1 = x1_ff + EW'(1);
                  p.x2 = x2_ff - EW'(1);
                  p.y2 = y2_ff;
               end
            endcase
         end
         CMD_INV_AREA: begin
            p.kind = PK_INVERT;
            p.x2   = x2_ff;
            p.y2   = y2_ff;
         end
         CMD_CLR_AREA: begin
            p.kind  = PK_WRITE;
            p.color = cfg.bg;
            p.x2    = x2_ff;
            p.y2    = y2_ff;
         end
         CMD_CLEAR: begin
            // widest range, clipped to the screen by the back end
            p.kind  = PK_WRITE;
            p.color = cfg.bg;
            p.x1    = '0;
            p.y1    = '0;
            p.x2    = {1'b0, {(EW-1){1'b1}}};
            p.y2    = {1'b0, {(EW-1){1'b1}}};
         end
         CMD_READ: p.kind = PK_READ;
         default: p.kind = PK_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         x1_ff    <= EW'(req_x_start);
         x2_ff    <= EW'(req_x_end);
         y1_ff    <= EW'(req_y_start);
         y2_ff    <= EW'(req_y_end);
         color_ff <= req_pixel_color;
         bits_ff  <= req_pattern_byte;
         fill_ff  <= req_fill_flag;
      end
   end

endmodule
`default_nettype wire

/* sv/rde_back.sv */
// back end: clips primitives and walks them over the frame store
`default_nettype none
module rde_back
   import rde_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire prim_type q_head,
   input  wire logic     q_empty,
   output logic          q_pop,
   output logic          init_busy,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output logic [7:0]    rsp_read_value,
   output logic          rsp_read_valid
);

   localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW   = $clog2(NPIX);
   localparam int XW   = $clog2(SCREEN_WIDTH);
   localparam int YW   = $clog2(SCREEN_HEIGHT);
   localparam logic signed [EW-1:0] XMAX = EW'(SCREEN_WIDTH - 1);
   localparam logic signed [EW-1:0] YMAX = EW'(SCREEN_HEIGHT - 1);

   logic [7:0]     mem [NPIX];
   logic [7:0]     rd_data_ff;

   back_state_type state_ff, state_in;
   prim_type       cur_ff;
   logic [XW-1:0]  xlo_ff, xhi_ff, x_ff;
   logic [YW-1:0]  ylo_ff, yhi_ff, y_ff;
   logic [AW-1:0]  row_ff, init_ff;
   logic [7:0]     res_val_ff;
   logic           res_vld_ff;
   logic           rsp_valid_ff;
   logic [7:0]     rsp_value_ff;
   logic           rsp_vld_bit_ff;

   logic signed [EW-1:0] cxlo, cxhi, cylo, cyhi;
   logic           clip_empty;
   logic           mem_we, mem_re;
   logic [AW-1:0]  mem_addr;
   logic [7:0]     mem_wd;
   logic           advance, last_px, load_rsp;
   logic [2:0]     bit_idx;
   logic           pat_bit;

   // clip of the queue head
   always_comb begin
      cxlo = (q_head.x1 < 0) ? '0 : q_head.x1;
      cxhi = (q_head.x2 > XMAX) ? XMAX : q_head.x2;
      cylo = (q_head.y1 < 0) ? '0 : q_head.y1;
      cyhi = (q_head.y2 > YMAX) ? YMAX : q_head.y2;
      clip_empty = (cxlo > cxhi) || (cylo > cyhi) || (q_head.kind == PK_NOP);
   end

   always_comb begin
      bit_idx = cur_ff.vert ? (y_ff[2:0] - cur_ff.y1[2:0]) : (x_ff[2:0] - cur_ff.x1[2:0]);
      pat_bit = cur_ff.vert ? cur_ff.bits[bit_idx] : cur_ff.bits[3'd7 - bit_idx];
      last_px = (x_ff == xhi_ff) && (y_ff == yhi_ff);
   end

   // outputs
   always_comb begin
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_addr = row_ff + AW'(x_ff);
      mem_wd   = cur_ff.color;
      advance  = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         B_INIT: begin
            mem_we   = 1'b1;
            mem_addr = init_ff;
            mem_wd   = '0;
         end
         B_IDLE: q_pop = !q_empty;
         B_RUN: begin
            case (cur_ff.kind)
               PK_WRITE: mem_we = 1'b1;
               PK_INVERT, PK_READ: mem_re = 1'b1;
               PK_PAT: begin
                  case (cur_ff.mode)
                     MODE_OPAQUE: begin
                        mem_we = 1'b1;
                        mem_wd = pat_bit ? cur_ff.color : cur_ff.bg;
                     end
                     MODE_TRANSP: mem_we = pat_bit;
                     MODE_INVERT: mem_re = pat_bit;
                     default: mem_we = 1'b0;
                  endcase
               end
               default: mem_we = 1'b0;
            endcase
            advance = !mem_re;
         end
         B_INV: begin
            mem_we  = 1'b1;
            mem_wd  = ~rd_data_ff;
            advance = 1'b1;
         end
         B_DONE: load_rsp = cur_ff.last && (!rsp_valid_ff || !rsp_stall);
         default: mem_we = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_INIT: if (init_ff == AW'(NPIX - 1)) state_in = B_IDLE;
         B_IDLE: begin
            if (!q_empty) begin
               state_in = clip_empty ? B_DONE : B_ROW;
            end
         end
         B_ROW: state_in = B_RUN;
         B_RUN: begin
            if (mem_re) begin
               state_in = (cur_ff.kind == PK_READ) ? B_RDW : B_INV;
            end else if (last_px) begin
               state_in = B_DONE;
            end
         end
         B_INV: state_in = last_px ? B_DONE : B_RUN;
         B_RDW: state_in = B_DONE;
         B_DONE: begin
            if (!cur_ff.last || load_rsp) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_INIT;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_INIT) begin
            init_ff <= init_ff + 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff     <= q_head;
         xlo_ff     <= XW'(cxlo);
         xhi_ff     <= XW'(cxhi);
         ylo_ff     <= YW'(cylo);
         yhi_ff     <= YW'(cyhi);
         res_val_ff <= '0;
         res_vld_ff <= 1'b0;
      end
      if (state_ff == B_ROW) begin
         row_ff <= AW'(ylo_ff) * AW'(SCREEN_WIDTH);
         x_ff   <= xlo_ff;
         y_ff   <= ylo_ff;
      end
      if (advance && !last_px) begin
         if (x_ff == xhi_ff) begin
            x_ff   <= xlo_ff;
            y_ff   <= y_ff + 1'b1;
            row_ff <= row_ff + AW'(SCREEN_WIDTH);
         end else begin
            x_ff <= x_ff + 1'b1;
         end
      end
      if (state_ff == B_RDW) begin
         res_val_ff <= rd_data_ff;
         res_vld_ff <= 1'b1;
      end
      if (load_rsp) begin
         rsp_value_ff   <= res_val_ff;
         rsp_vld_bit_ff <= res_vld_ff;
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   assign init_busy      = (state_ff == B_INIT);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_read_valid = rsp_vld_bit_ff;

endmodule
`default_nettype wire
